// ===== rtl/m3i_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package m3i_pkg;
   localparam int ENTRY_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int THR_W       = 31;
   localparam int N_ENT       = 9;
   localparam int N_ROW       = 3;
endpackage
`default_nettype wire

// ===== rtl/m3i_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface m3i_req_if #(parameter int ENTRY_WIDTH = m3i_pkg::ENTRY_WIDTH) ();
   logic                          valid;
   logic                          ready;
   logic signed [ENTRY_WIDTH-1:0] in_r0c0;
   logic signed [ENTRY_WIDTH-1:0] in_r0c1;
   logic signed [ENTRY_WIDTH-1:0] in_r0c2;
   logic signed [ENTRY_WIDTH-1:0] in_r1c0;
   logic signed [ENTRY_WIDTH-1:0] in_r1c1;
   logic signed [ENTRY_WIDTH-1:0] in_r1c2;
   logic signed [ENTRY_WIDTH-1:0] in_r2c0;
   logic signed [ENTRY_WIDTH-1:0] in_r2c1;
   logic signed [ENTRY_WIDTH-1:0] in_r2c2;
   modport source (output valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                   in_r2c0, in_r2c1, in_r2c2, input ready);
   modport sink (input valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                 in_r2c0, in_r2c1, in_r2c2, output ready);
endinterface

interface m3i_rsp_if #(parameter int ENTRY_WIDTH = m3i_pkg::ENTRY_WIDTH) ();
   logic                          valid;
   logic                          ready;
   logic signed [ENTRY_WIDTH-1:0] inv_r0c0;
   logic signed [ENTRY_WIDTH-1:0] inv_r0c1;
   logic signed [ENTRY_WIDTH-1:0] inv_r0c2;
   logic signed [ENTRY_WIDTH-1:0] inv_r1c0;
   logic signed [ENTRY_WIDTH-1:0] inv_r1c1;
   logic signed [ENTRY_WIDTH-1:0] inv_r1c2;
   logic signed [ENTRY_WIDTH-1:0] inv_r2c0;
   logic signed [ENTRY_WIDTH-1:0] inv_r2c1;
   logic signed [ENTRY_WIDTH-1:0] inv_r2c2;
   logic signed [ENTRY_WIDTH-1:0] det_value;
   logic                          singular;
   modport source (output valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1,
                   inv_r1c2, inv_r2c0, inv_r2c1, inv_r2c2, det_value, singular,
                   input ready);
   modport sink (input valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1,
                 inv_r1c2, inv_r2c0, inv_r2c1, inv_r2c2, det_value, singular,
                 output ready);
endinterface
`default_nettype wire

// ===== rtl/matrix3x3_inverse_core.sv =====
// Channel  Port       Direction  Carries
// req      req_ch     in         nine matrix entries, row by row
// rsp      rsp_ch     out        nine inverse entries, determinant, singular flag
// csr      csr_we/..  in         singular threshold register
//
// One transaction enters per cycle unless the output stalls; the restoring divider
// produces one quotient bit per stage in each of nine lanes.
// Reset clears every valid bit and the threshold; the payload registers are not reset.
// A stalled output holds the whole pipeline in place; nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none
module matrix3x3_inverse_core #(
   parameter int ENTRY_WIDTH = m3i_pkg::ENTRY_WIDTH,
   parameter int FRAC_BITS   = m3i_pkg::FRAC_BITS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   m3i_req_if.sink                         req_ch,
   m3i_rsp_if.source                       rsp_ch,
   input  wire logic                       csr_we,
   input  wire logic [m3i_pkg::THR_W-1:0]  csr_wdata
);
   localparam int W      = ENTRY_WIDTH;
   localparam int NE     = m3i_pkg::N_ENT;
   localparam int COF_W  = 2 * W + 1;
   localparam int DET_W  = 3 * W + 3;
   localparam int DMAG_W = DET_W;
   localparam int CMP_W  = DMAG_W + m3i_pkg::THR_W + 2 * FRAC_BITS;
   localparam int AW     = m3i_pkg::THR_W + W;

   logic                      adv;
   logic signed [W-1:0]       ent_w [NE];
   logic                      vld2_w, vld5_w;
   logic signed [COF_W-1:0]   cof2_w [NE];
   logic signed [W-1:0]       row2_w [m3i_pkg::N_ROW];
   logic signed [DET_W-1:0]   det5_w;
   logic signed [COF_W-1:0]   cof5_w [NE];
   logic [m3i_pkg::THR_W-1:0] thr_ff;

   logic                      vld6_ff;
   logic [DMAG_W-1:0]         dmag_ff;
   logic                      dneg_ff;
   logic [COF_W-1:0]          amag_ff [NE];
   logic                      rneg_ff [NE];

   logic                      sing_in;
   logic [DMAG_W-1:0]         dsh_w;
   logic [W-1:0]              dlim_w, dm_w, detv_in;
   logic                      vld_ff  [W+1];
   logic                      sing_ff [W+1];
   logic [W-1:0]              detv_ff [W+1];

   logic [W-1:0]              q_w   [NE];
   logic                      neg_w [NE];
   logic                      ovf_w [NE];
   logic [W-1:0]              inv_in [NE];

   logic                      out_vld_ff;
   logic [W-1:0]              out_inv_ff [NE];
   logic [W-1:0]              out_det_ff;
   logic                      out_sing_ff;

   assign adv          = !out_vld_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   assign ent_w[0] = req_ch.in_r0c0;
   assign ent_w[1] = req_ch.in_r0c1;
   assign ent_w[2] = req_ch.in_r0c2;
   assign ent_w[3] = req_ch.in_r1c0;
   assign ent_w[4] = req_ch.in_r1c1;
   assign ent_w[5] = req_ch.in_r1c2;
   assign ent_w[6] = req_ch.in_r2c0;
   assign ent_w[7] = req_ch.in_r2c1;
   assign ent_w[8] = req_ch.in_r2c2;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   m3i_cofactor #(.ENTRY_WIDTH(W)) u_cofactor (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .vld_in  (req_ch.valid),
      .ent_in  (ent_w),
      .vld_out (vld2_w),
      .cof_out (cof2_w),
      .row_out (row2_w)
   );

   m3i_det #(.ENTRY_WIDTH(W)) u_det (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .vld_in  (vld2_w),
      .cof_in  (cof2_w),
      .row_in  (row2_w),
      .vld_out (vld5_w),
      .det_out (det5_w),
      .cof_out (cof5_w)
   );

   // take magnitudes and result signs
   always_ff @(posedge clock) begin
      if (reset) begin
         vld6_ff <= 1'b0;
      end else if (adv) begin
         vld6_ff <= vld5_w;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dneg_ff <= det5_w[DET_W-1];
         dmag_ff <= det5_w[DET_W-1] ? DMAG_W'(-det5_w) : DMAG_W'(det5_w);
         for (int k = 0; k < NE; k++) begin
            amag_ff[k] <= cof5_w[k][COF_W-1] ? COF_W'(-cof5_w[k]) : COF_W'(cof5_w[k]);
            rneg_ff[k] <= cof5_w[k][COF_W-1] ^ det5_w[DET_W-1];
         end
      end
   end

   for (genvar k = 0; k < NE; k++) begin : g_lane
      m3i_div_lane #(.ENTRY_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_lane (
         .clock      (clock),
         .adv        (adv),
         .adj_mag_in (amag_ff[k]),
         .neg_in     (rneg_ff[k]),
         .dmag_in    (dmag_ff),
         .q_out      (q_w[k]),
         .neg_out    (neg_w[k]),
         .ovf_out    (ovf_w[k])
      );
   end

   // threshold test and saturated determinant
   always_comb begin
      sing_in = CMP_W'(dmag_ff) <= (CMP_W'(thr_ff) << (2 * FRAC_BITS));
      dsh_w   = dmag_ff >> (2 * FRAC_BITS);
      dlim_w  = {1'b1, {(W-1){1'b0}}} - W'(!dneg_ff);
      dm_w    = (dsh_w > DMAG_W'(dlim_w)) ? dlim_w : dsh_w[W-1:0];
      detv_in = dneg_ff ? W'(-dm_w) : dm_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= W; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= vld6_ff;
         for (int s = 1; s <= W; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sing_ff[0] <= sing_in;
         detv_ff[0] <= detv_in;
         for (int s = 1; s <= W; s++) begin
            sing_ff[s] <= sing_ff[s-1];
            detv_ff[s] <= detv_ff[s-1];
         end
      end
   end

   // saturate quotients, zero on singular
   always_comb begin
      logic [W-1:0] lim, m;
      for (int k = 0; k < NE; k++) begin
         lim = {1'b1, {(W-1){1'b0}}} - W'(!neg_w[k]);
         m   = (ovf_w[k] || q_w[k] > lim) ? lim : q_w[k];
         inv_in[k] = sing_ff[W] ? '0 : (neg_w[k] ? W'(-m) : m);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= vld_ff[W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_inv_ff  <= inv_in;
         out_det_ff  <= detv_ff[W];
         out_sing_ff <= sing_ff[W];
      end
   end

   assign rsp_ch.valid     = out_vld_ff;
   assign rsp_ch.inv_r0c0  = out_inv_ff[0];
   assign rsp_ch.inv_r0c1  = out_inv_ff[1];
   assign rsp_ch.inv_r0c2  = out_inv_ff[2];
   assign rsp_ch.inv_r1c0  = out_inv_ff[3];
   assign rsp_ch.inv_r1c1  = out_inv_ff[4];
   assign rsp_ch.inv_r1c2  = out_inv_ff[5];
   assign rsp_ch.inv_r2c0  = out_inv_ff[6];
   assign rsp_ch.inv_r2c1  = out_inv_ff[7];
   assign rsp_ch.inv_r2c2  = out_inv_ff[8];
   assign rsp_ch.det_value = out_det_ff;
   assign rsp_ch.singular  = out_sing_ff;

   logic         inv_zero_w;
   logic [W-1:0] det_abs_w;

   always_comb begin
      inv_zero_w = 1'b1;
      for (int k = 0; k < NE; k++) begin
         inv_zero_w = inv_zero_w && (out_inv_ff[k] == '0);
      end
      det_abs_w = out_det_ff[W-1] ? W'(-out_det_ff) : out_det_ff;
   end

   a_sing_zero : assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_sing_ff |-> inv_zero_w)
      else $error("singular result carries nonzero inverse entries");

   a_sing_small : assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_sing_ff |-> AW'(det_abs_w) <= AW'(thr_ff))
      else $error("singular result with determinant above threshold");

   a_zero_det : assert property (@(posedge clock) disable iff (reset)
      adv && vld6_ff && dmag_ff == '0 |=> sing_ff[0])
      else $error("zero determinant not flagged singular");

   a_reset_idle : assert property (@(posedge clock)
      reset |=> !out_vld_ff && !vld6_ff)
      else $error("valid bits survive reset");
endmodule
`default_nettype wire

// ===== rtl/m3i_cofactor.sv =====
`timescale 1ns / 1ps
`default_nettype none
module m3i_cofactor #(
   parameter int ENTRY_WIDTH = m3i_pkg::ENTRY_WIDTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          adv,
   input  wire logic                          vld_in,
   input  wire logic signed [ENTRY_WIDTH-1:0] ent_in  [m3i_pkg::N_ENT],
   output logic                               vld_out,
   output logic signed [2*ENTRY_WIDTH:0]      cof_out [m3i_pkg::N_ENT],
   output logic signed [ENTRY_WIDTH-1:0]      row_out [m3i_pkg::N_ROW]
);
   localparam int PROD_W = 2 * ENTRY_WIDTH;
   localparam int COF_W  = 2 * ENTRY_WIDTH + 1;
   localparam int unsigned IDX_A [m3i_pkg::N_ENT] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
   localparam int unsigned IDX_B [m3i_pkg::N_ENT] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
   localparam int unsigned IDX_C [m3i_pkg::N_ENT] = '{7, 1, 2, 3, 2, 0, 4, 0, 1};
   localparam int unsigned IDX_D [m3i_pkg::N_ENT] = '{5, 8, 4, 8, 6, 5, 6, 7, 3};

   logic                          vld1_ff, vld2_ff;
   logic signed [PROD_W-1:0]      pa_ff [m3i_pkg::N_ENT];
   logic signed [PROD_W-1:0]      pb_ff [m3i_pkg::N_ENT];
   logic signed [COF_W-1:0]       cof_ff [m3i_pkg::N_ENT];
   logic signed [ENTRY_WIDTH-1:0] row1_ff [m3i_pkg::N_ROW];
   logic signed [ENTRY_WIDTH-1:0] row2_ff [m3i_pkg::N_ROW];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff <= vld_in;
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < m3i_pkg::N_ENT; k++) begin
            pa_ff[k]  <= ent_in[IDX_A[k]] * ent_in[IDX_B[k]];
            pb_ff[k]  <= ent_in[IDX_C[k]] * ent_in[IDX_D[k]];
            cof_ff[k] <= COF_W'(pa_ff[k]) - COF_W'(pb_ff[k]);
         end
         for (int j = 0; j < m3i_pkg::N_ROW; j++) begin
            row1_ff[j] <= ent_in[j];
            row2_ff[j] <= row1_ff[j];
         end
      end
   end

   assign vld_out = vld2_ff;
   assign cof_out = cof_ff;
   assign row_out = row2_ff;
endmodule
`default_nettype wire

// ===== rtl/m3i_det.sv =====
`timescale 1ns / 1ps
`default_nettype none
module m3i_det #(
   parameter int ENTRY_WIDTH = m3i_pkg::ENTRY_WIDTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          adv,
   input  wire logic                          vld_in,
   input  wire logic signed [2*ENTRY_WIDTH:0] cof_in  [m3i_pkg::N_ENT],
   input  wire logic signed [ENTRY_WIDTH-1:0] row_in  [m3i_pkg::N_ROW],
   output logic                               vld_out,
   output logic signed [3*ENTRY_WIDTH+2:0]    det_out,
   output logic signed [2*ENTRY_WIDTH:0]      cof_out [m3i_pkg::N_ENT]
);
   localparam int W     = ENTRY_WIDTH;
   localparam int COF_W = 2 * W + 1;
   localparam int PP_W  = 2 * W + 1;
   localparam int DET_W = 3 * W + 3;
   localparam int unsigned COL_IDX [m3i_pkg::N_ROW] = '{0, 3, 6};

   logic                    vld3_ff, vld4_ff, vld5_ff;
   logic signed [W:0]       lo_w [m3i_pkg::N_ROW];
   logic signed [W:0]       hi_w [m3i_pkg::N_ROW];
   logic signed [PP_W-1:0]  pl_ff [m3i_pkg::N_ROW];
   logic signed [PP_W-1:0]  ph_ff [m3i_pkg::N_ROW];
   logic signed [DET_W-1:0] t_ff [m3i_pkg::N_ROW];
   logic signed [DET_W-1:0] det_ff;
   logic signed [COF_W-1:0] cof3_ff [m3i_pkg::N_ENT];
   logic signed [COF_W-1:0] cof4_ff [m3i_pkg::N_ENT];
   logic signed [COF_W-1:0] cof5_ff [m3i_pkg::N_ENT];

   always_comb begin
      for (int j = 0; j < m3i_pkg::N_ROW; j++) begin
         lo_w[j] = signed'({1'b0, cof_in[COL_IDX[j]][W-1:0]});
         hi_w[j] = cof_in[COL_IDX[j]][COF_W-1:W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
      end else if (adv) begin
         vld3_ff <= vld_in;
         vld4_ff <= vld3_ff;
         vld5_ff <= vld4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < m3i_pkg::N_ROW; j++) begin
            pl_ff[j] <= row_in[j] * lo_w[j];
            ph_ff[j] <= row_in[j] * hi_w[j];
            t_ff[j]  <= (DET_W'(ph_ff[j]) <<< W) + DET_W'(pl_ff[j]);
         end
         det_ff <= t_ff[0] + t_ff[1] + t_ff[2];
         cof3_ff <= cof_in;
         cof4_ff <= cof3_ff;
         cof5_ff <= cof4_ff;
      end
   end

   assign vld_out = vld5_ff;
   assign det_out = det_ff;
   assign cof_out = cof5_ff;
endmodule
`default_nettype wire

// ===== rtl/m3i_div_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
module m3i_div_lane #(
   parameter int ENTRY_WIDTH = m3i_pkg::ENTRY_WIDTH,
   parameter int FRAC_BITS   = m3i_pkg::FRAC_BITS
) (
   input  wire logic                     clock,
   input  wire logic                     adv,
   input  wire logic [2*ENTRY_WIDTH:0]   adj_mag_in,
   input  wire logic                     neg_in,
   input  wire logic [3*ENTRY_WIDTH+2:0] dmag_in,
   output logic [ENTRY_WIDTH-1:0]        q_out,
   output logic                          neg_out,
   output logic                          ovf_out
);
   localparam int W      = ENTRY_WIDTH;
   localparam int ADJ_W  = 2 * W + 1;
   localparam int DMAG_W = 3 * W + 3;
   localparam int N_W    = ADJ_W + 2 * FRAC_BITS;
   localparam int HI_W   = N_W - W;

   logic [N_W-1:0]    n_w;
   logic [HI_W-1:0]   nhi_w;
   logic [DMAG_W-1:0] rem_ff [W+1];
   logic [DMAG_W-1:0] d_ff   [W+1];
   logic [W-1:0]      low_ff [W+1];
   logic [W-1:0]      q_ff   [W+1];
   logic              neg_ff [W+1];
   logic              ovf_ff [W+1];

   assign n_w   = N_W'(adj_mag_in) << (2 * FRAC_BITS);
   assign nhi_w = n_w[N_W-1:W];

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= DMAG_W'(nhi_w);
         d_ff[0]   <= dmag_in;
         low_ff[0] <= n_w[W-1:0];
         q_ff[0]   <= '0;
         neg_ff[0] <= neg_in;
         ovf_ff[0] <= DMAG_W'(nhi_w) >= dmag_in;
      end
   end

   for (genvar s = 1; s <= W; s++) begin : g_step
      logic [DMAG_W:0]   t_w;
      logic              ge_w;
      logic [DMAG_W-1:0] rem_in;

      always_comb begin
         t_w    = {rem_ff[s-1], low_ff[s-1][W-s]};
         ge_w   = t_w >= {1'b0, d_ff[s-1]};
         rem_in = ge_w ? DMAG_W'(t_w - {1'b0, d_ff[s-1]}) : t_w[DMAG_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s] <= rem_in;
            d_ff[s]   <= d_ff[s-1];
            low_ff[s] <= low_ff[s-1];
            q_ff[s]   <= {q_ff[s-1][W-2:0], ge_w};
            neg_ff[s] <= neg_ff[s-1];
            ovf_ff[s] <= ovf_ff[s-1];
         end
      end
   end

   assign q_out   = q_ff[W];
   assign neg_out = neg_ff[W];
   assign ovf_out = ovf_ff[W];
endmodule
`default_nettype wire

// ===== tb/sv/matrix3x3_inverse_core_test.sv =====
`timescale 1ns / 1ps
module matrix3x3_inverse_core_test;

   localparam int W = m3i_pkg::ENTRY_WIDTH;
   localparam int LATENCY = m3i_pkg::ENTRY_WIDTH + 8;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef logic signed [W-1:0] entry_type;
   typedef struct packed {
      entry_type [m3i_pkg::N_ENT-1:0] inv;
      entry_type                      det;
      logic                           sing;
   } inverse_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [m3i_pkg::THR_W-1:0] csr_wdata = '0;

   m3i_req_if req_ch ();
   m3i_rsp_if rsp_ch ();

   matrix3x3_inverse_core u_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   logic [m3i_pkg::THR_W-1:0] threshold = '0;
   inverse_type expected_q[$];
   int mismatches = 0;
   int sent = 0;
   int received = 0;
   int singular_seen = 0;
   int idle_cycles = 0;
   bit calm = 1'b0;

   // exact signed math on 200-bit values
   function automatic logic signed [199:0] ext(entry_type e);
      return {{(200-W){e[W-1]}}, e};
   endfunction

   function automatic entry_type clamp(logic signed [199:0] v);
      logic signed [199:0] hi, lo;
      hi = (200'sd1 <<< (W-1)) - 1;
      lo = -(200'sd1 <<< (W-1));
      if (v > hi) return hi[W-1:0];
      if (v < lo) return lo[W-1:0];
      return v[W-1:0];
   endfunction

   function automatic inverse_type invert_matrix(entry_type m[m3i_pkg::N_ENT]);
      logic signed [199:0] a[m3i_pkg::N_ENT], adj[m3i_pkg::N_ENT], det, dmag, amag, q, thr;
      inverse_type r;
      for (int k = 0; k < m3i_pkg::N_ENT; k++) a[k] = ext(m[k]);
      adj[0] = a[4]*a[8] - a[7]*a[5];
      adj[1] = a[2]*a[7] - a[1]*a[8];
      adj[2] = a[1]*a[5] - a[2]*a[4];
      adj[3] = a[5]*a[6] - a[3]*a[8];
      adj[4] = a[0]*a[8] - a[2]*a[6];
      adj[5] = a[2]*a[3] - a[0]*a[5];
      adj[6] = a[3]*a[7] - a[4]*a[6];
      adj[7] = a[1]*a[6] - a[0]*a[7];
      adj[8] = a[0]*a[4] - a[1]*a[3];
      det = a[0]*adj[0] + a[1]*adj[3] + a[2]*adj[6];
      dmag = (det < 0) ? -det : det;
      thr = {169'd0, threshold} <<< (2*m3i_pkg::FRAC_BITS);
      r.sing = (dmag <= thr);
      for (int k = 0; k < m3i_pkg::N_ENT; k++) begin
         if (r.sing) begin
            r.inv[k] = '0;
         end else begin
            amag = (adj[k] < 0) ? -adj[k] : adj[k];
            q = (amag <<< (2*m3i_pkg::FRAC_BITS)) / dmag;
            r.inv[k] = clamp(((adj[k] < 0) != (det < 0)) ? -q : q);
         end
      end
      q = dmag >>> (2*m3i_pkg::FRAC_BITS);
      r.det = clamp((det < 0) ? -q : q);
      return r;
   endfunction

   task automatic send_matrix(entry_type m[m3i_pkg::N_ENT]);
      while (!calm && $urandom_range(99) < 14) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.in_r0c0 <= m[0]; req_ch.in_r0c1 <= m[1]; req_ch.in_r0c2 <= m[2];
      req_ch.in_r1c0 <= m[3]; req_ch.in_r1c1 <= m[4]; req_ch.in_r1c2 <= m[5];
      req_ch.in_r2c0 <= m[6]; req_ch.in_r2c1 <= m[7]; req_ch.in_r2c2 <= m[8];
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_q.push_back(invert_matrix(m));
      sent++;
   endtask

   task automatic stop_sending();
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_pipe();
      while (expected_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_threshold(logic [m3i_pkg::THR_W-1:0] v);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      threshold = v;
      @(posedge clock);
   endtask

   function automatic entry_type rand_entry(int mode);
      case (mode)
         0: return $urandom();
         1: return entry_type'($signed($urandom_range(0, 'h7_0000)) - 'sh3_8000);
         2: return entry_type'($signed($urandom_range(0, 'h2000)) - 'sh1000);
         default: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
      endcase
   endfunction

   task automatic send_random(int mode);
      entry_type m[m3i_pkg::N_ENT];
      int r;
      for (int k = 0; k < m3i_pkg::N_ENT; k++) m[k] = rand_entry(mode);
      r = $urandom_range(0, 5);
      // force linear dependence to hit the singular path
      if (r == 0) for (int k = 0; k < 3; k++) m[6+k] = m[k];
      if (r == 1) for (int k = 0; k < 3; k++) m[3+k] = m[k] <<< 1;
      send_matrix(m);
   endtask

   task automatic test_directed();
      entry_type m[m3i_pkg::N_ENT];
      entry_type one, mx, mn;
      one = 1 <<< m3i_pkg::FRAC_BITS;
      mx = 32'h7fff_ffff;
      mn = 32'h8000_0000;
      m = '{one, 0, 0, 0, one, 0, 0, 0, one}; send_matrix(m);
      m = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_matrix(m);
      m = '{mx, 0, 0, 0, mx, 0, 0, 0, mx}; send_matrix(m);
      m = '{mn, 0, 0, 0, mn, 0, 0, 0, mn}; send_matrix(m);
      m = '{mn, mn, mn, mn, mn, mn, mn, mn, mn}; send_matrix(m);
      m = '{mx, mn, mx, mn, mx, mn, mx, mn, mx}; send_matrix(m);
      m = '{mx, 0, 0, 0, mn, 0, 0, 0, mx}; send_matrix(m);
      m = '{1, 0, 0, 0, 1, 0, 0, 0, 1}; send_matrix(m);
      m = '{-1, 0, 0, 0, 1, 0, 0, 0, 1}; send_matrix(m);
      m = '{0, one, 0, one, 0, 0, 0, 0, -one}; send_matrix(m);
      m = '{2*one, one, 0, one, 3*one, one, 0, one, 4*one}; send_matrix(m);
      m = '{one, 2*one, 3*one, 4*one, 5*one, 6*one, 7*one, 8*one, 9*one}; send_matrix(m);
      m = '{-1, -1, -1, -1, -1, -1, -1, -1, -1}; send_matrix(m);
      m = '{one/2, 0, 0, 0, one/2, 0, 0, 0, one/2}; send_matrix(m);
      m = '{256, 0, 0, 0, 256, 0, 0, 0, 256}; send_matrix(m);
      m = '{mx, 1, 0, 1, mx, 0, 0, 0, 1}; send_matrix(m);
      stop_sending();
   endtask

   task automatic test_thresholds();
      logic [m3i_pkg::THR_W-1:0] levels[5];
      levels = '{31'd1, 31'h1_0000, 31'h10_0000, 31'h7fff_ffff, 31'd0};
      foreach (levels[i]) begin
         drain_pipe();
         write_threshold(levels[i]);
         repeat (60) send_random($urandom_range(0, 3));
         stop_sending();
      end
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         calm = (i >= count / 2) && (i < count / 2 + 200);
         send_random($urandom_range(0, 9) < 3 ? 0 : $urandom_range(1, 3));
      end
      calm = 1'b0;
      stop_sending();
   endtask

   task automatic test_random_threshold(int count);
      drain_pipe();
      write_threshold($urandom_range(0, 'h7fff_ffff));
      test_random(count);
   endtask

   // result checker and ready generator
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            inverse_type got, want;
            got.inv = {rsp_ch.inv_r2c2, rsp_ch.inv_r2c1, rsp_ch.inv_r2c0,
                       rsp_ch.inv_r1c2, rsp_ch.inv_r1c1, rsp_ch.inv_r1c0,
                       rsp_ch.inv_r0c2, rsp_ch.inv_r0c1, rsp_ch.inv_r0c0};
            got.det = rsp_ch.det_value;
            got.sing = rsp_ch.singular;
            received++;
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected transaction %0d", received);
            end else begin
               want = expected_q.pop_front();
               if (want.sing) singular_seen++;
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch transaction %0d", received);
                     for (int k = 0; k < m3i_pkg::N_ENT; k++)
                        if (got.inv[k] !== want.inv[k])
                           $display("  inv[%0d] exp %h got %h", k, want.inv[k], got.inv[k]);
                     $display("  det exp %h got %h, singular exp %b got %b",
                              want.det, got.det, want.sing, got.sing);
                  end
               end
            end
         end
         rsp_ch.ready <= calm || ($urandom_range(99) >= 14);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.in_r0c0 = '0; req_ch.in_r0c1 = '0; req_ch.in_r0c2 = '0;
      req_ch.in_r1c0 = '0; req_ch.in_r1c1 = '0; req_ch.in_r1c2 = '0;
      req_ch.in_r2c0 = '0; req_ch.in_r2c1 = '0; req_ch.in_r2c2 = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_thresholds();
      test_random(1000);
      test_random_threshold(300);
      drain_pipe();
      $display("Covered %0d matrices (%0d singular) over several threshold settings.",
               sent, singular_seen);
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches, %0d left over", mismatches, expected_q.size());
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
